// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("Assertion failed.");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("Forbidden condition seen.");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// File: hw/rtl/dvr_pkg.sv
// ----------------------------------------------------------------------------
// dvr_pkg
// Types and constants of the distance-vector route update unit.
// ----------------------------------------------------------------------------
package dvr_pkg;

   localparam int INDEX_WIDTH = 4;
   localparam int VALUE_WIDTH = 16;
   localparam int COUNT_WIDTH = 5;
   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 5'd16;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_ADVERT = 1'b1;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      value_type router_id;
      value_type cost;
      value_type next_hop;
   } route_entry_type;

endpackage

// File: hw/rtl/distance_vector_route_update_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update_unit
// Route table with load and Bellman-Ford relaxation of advertised routes.
//
//   Channel  Ports   Direction  Word
//   request  req_*   in         operation, indexes, cost, load fields
//   response rsp_*   out        changed flag, entry cost, entry next hop
//   csr      csr_*   in         router count
//
// A load passes through states LOAD and DONE, an advertisement through RD_SND,
// RD_DST, EVAL and DONE. An equal-cost tie with a nonzero router count adds a
// search of the table memory, one entry a cycle, over min(router_count,
// MAX_ROUTERS) entries, followed by states TIE_WAIT and TIE before DONE.
// Reset is synchronous; the table contents are undefined until loaded.
// A stalled response waits in its register; a new request is still taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module distance_vector_route_update_unit #(
   parameter int MAX_ROUTERS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  dvr_pkg::index_type          req_entry_index,
   input  dvr_pkg::index_type          req_sender_index,
   input  dvr_pkg::value_type          req_advertised_cost,
   input  dvr_pkg::value_type          req_load_router_id,
   input  dvr_pkg::value_type          req_load_cost,
   input  dvr_pkg::value_type          req_load_next_hop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_route_changed,
   output dvr_pkg::value_type          rsp_entry_cost,
   output dvr_pkg::value_type          rsp_entry_next_hop,
   input  logic                        csr_write_enable,
   input  dvr_pkg::count_type          csr_write_data
);

   import dvr_pkg::*;

   localparam int AW = (MAX_ROUTERS > 1) ? $clog2(MAX_ROUTERS) : 1;
   localparam int CW = $clog2(MAX_ROUTERS + 1);
   localparam int WW = ((CW > COUNT_WIDTH) ? CW : COUNT_WIDTH) + 1;

   typedef enum logic [3:0] {
      IDLE, LOAD, RD_SND, RD_DST, EVAL, SEARCH, TIE_WAIT, TIE, DONE
   } state_type;

   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_changed_ff, rsp_changed_in;
   value_type        rsp_cost_ff, rsp_cost_in;
   value_type        rsp_hop_ff, rsp_hop_in;
   count_type        count_ff, count_in;

   logic             op_ff, op_in;
   index_type        dst_ff, dst_in;
   index_type        snd_ff, snd_in;
   value_type        adv_ff, adv_in;
   route_entry_type  load_ff, load_in;
   route_entry_type  sender_ff, sender_in;
   route_entry_type  dest_ff, dest_in;
   logic [AW-1:0]    scan_ff, scan_in;
   logic             check_ff, check_in;
   logic             found_ff, found_in;
   value_type        hop_cost_ff, hop_cost_in;
   logic             res_changed_ff, res_changed_in;
   value_type        res_cost_ff, res_cost_in;
   value_type        res_hop_ff, res_hop_in;

   route_entry_type  entry_mem [MAX_ROUTERS];
   route_entry_type  rd_data_ff;
   logic [AW-1:0]    rd_addr;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   route_entry_type  mem_wdata;

   logic [WW-1:0]    dst_wide;
   logic [WW-1:0]    snd_wide;
   logic [WW-1:0]    count_wide;
   logic [WW-1:0]    limit;
   logic             dst_ok;
   logic             snd_ok;
   logic [VALUE_WIDTH:0] sum;
   logic             req_take;

   assign req_stall = (state_ff != IDLE);
   assign req_take  = req_valid && !req_stall;

   assign dst_wide   = WW'(dst_ff);
   assign snd_wide   = WW'(snd_ff);
   assign count_wide = WW'(count_ff);
   assign limit      = (count_wide > WW'(MAX_ROUTERS)) ? WW'(MAX_ROUTERS) : count_wide;
   assign dst_ok     = dst_wide < WW'(MAX_ROUTERS);
   assign snd_ok     = snd_wide < WW'(MAX_ROUTERS);
   assign sum        = {1'b0, sender_ff.cost} + {1'b0, adv_ff};
   assign mem_waddr  = dst_wide[AW-1:0];

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_changed_in = rsp_changed_ff;
      rsp_cost_in    = rsp_cost_ff;
      rsp_hop_in     = rsp_hop_ff;
      count_in       = csr_write_enable ? csr_write_data : count_ff;
      op_in          = op_ff;
      dst_in         = dst_ff;
      snd_in         = snd_ff;
      adv_in         = adv_ff;
      load_in        = load_ff;
      sender_in      = sender_ff;
      dest_in        = dest_ff;
      scan_in        = scan_ff;
      check_in       = (state_ff == SEARCH);
      found_in       = found_ff;
      hop_cost_in    = hop_cost_ff;
      res_changed_in = res_changed_ff;
      res_cost_in    = res_cost_ff;
      res_hop_in     = res_hop_ff;
      rd_addr        = dst_wide[AW-1:0];
      mem_we         = 1'b0;
      mem_wdata      = dest_ff;

      if (check_ff && rd_data_ff.router_id == dest_ff.next_hop) begin
         found_in    = 1'b1;
         hop_cost_in = rd_data_ff.cost;
      end

      case (state_ff)
         IDLE: begin
            if (req_take) begin
               op_in             = req_operation;
               dst_in            = req_entry_index;
               snd_in            = req_sender_index;
               adv_in            = req_advertised_cost;
               load_in.router_id = req_load_router_id;
               load_in.cost      = req_load_cost;
               load_in.next_hop  = req_load_next_hop;
               state_in          = (req_operation == OP_LOAD) ? LOAD : RD_SND;
            end
         end
         LOAD: begin
            mem_wdata = load_ff;
            if (dst_ok) begin
               mem_we         = 1'b1;
               res_changed_in = 1'b0;
               res_cost_in    = load_ff.cost;
               res_hop_in     = load_ff.next_hop;
            end else begin
               res_changed_in = 1'b0;
               res_cost_in    = '0;
               res_hop_in     = '0;
            end
            state_in = DONE;
         end
         RD_SND: begin
            rd_addr  = snd_wide[AW-1:0];
            state_in = RD_DST;
         end
         RD_DST: begin
            sender_in = rd_data_ff;
            state_in  = EVAL;
         end
         EVAL: begin
            dest_in        = rd_data_ff;
            res_changed_in = 1'b0;
            res_cost_in    = rd_data_ff.cost;
            res_hop_in     = rd_data_ff.next_hop;
            state_in       = DONE;
            if (!dst_ok) begin
               res_cost_in = '0;
               res_hop_in  = '0;
            end else if (snd_ok) begin
               if (sum < {1'b0, rd_data_ff.cost}) begin
                  mem_we             = 1'b1;
                  mem_wdata          = rd_data_ff;
                  mem_wdata.cost     = sum[VALUE_WIDTH-1:0];
                  mem_wdata.next_hop = sender_ff.router_id;
                  res_changed_in     = 1'b1;
                  res_cost_in        = sum[VALUE_WIDTH-1:0];
                  res_hop_in         = sender_ff.router_id;
               end else if (sum == {1'b0, rd_data_ff.cost} && limit != '0) begin
                  scan_in  = '0;
                  found_in = 1'b0;
                  state_in = SEARCH;
               end
            end
         end
         SEARCH: begin
            rd_addr = scan_ff;
            if (WW'(scan_ff) == limit - WW'(1)) begin
               state_in = TIE_WAIT;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         TIE_WAIT: begin
            state_in = TIE;
         end
         TIE: begin
            res_changed_in = 1'b0;
            res_cost_in    = dest_ff.cost;
            res_hop_in     = dest_ff.next_hop;
            if (found_ff && hop_cost_ff > sender_ff.cost &&
                dest_ff.next_hop != sender_ff.router_id) begin
               mem_we             = 1'b1;
               mem_wdata.next_hop = sender_ff.router_id;
               res_changed_in     = 1'b1;
               res_hop_in         = sender_ff.router_id;
            end
            state_in = DONE;
         end
         DONE: begin
            if (!rsp_valid_in) begin
               rsp_valid_in   = 1'b1;
               rsp_changed_in = res_changed_ff;
               rsp_cost_in    = res_cost_ff;
               rsp_hop_in     = res_hop_ff;
               state_in       = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_changed_ff <= rsp_changed_in;
      rsp_cost_ff    <= rsp_cost_in;
      rsp_hop_ff     <= rsp_hop_in;
      op_ff          <= op_in;
      dst_ff         <= dst_in;
      snd_ff         <= snd_in;
      adv_ff         <= adv_in;
      load_ff        <= load_in;
      sender_ff      <= sender_in;
      dest_ff        <= dest_in;
      scan_ff        <= scan_in;
      found_ff       <= found_in;
      hop_cost_ff    <= hop_cost_in;
      res_changed_ff <= res_changed_in;
      res_cost_ff    <= res_cost_in;
      res_hop_ff     <= res_hop_in;
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_RESET;
         check_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         check_ff     <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_route_changed  = rsp_changed_ff;
   assign rsp_entry_cost     = rsp_cost_ff;
   assign rsp_entry_next_hop = rsp_hop_ff;

   `ASSERT_PROP(a_write_state, clock, reset,
      mem_we |-> (state_ff == LOAD || state_ff == EVAL || state_ff == TIE))
   `ASSERT_PROP(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == DONE))
   `ASSERT_PROP(a_scan_bound, clock, reset,
      (state_ff == SEARCH) |-> (WW'(scan_ff) < limit))
   `ASSERT_NEVER(a_write_out_of_table, clock, reset, mem_we && !dst_ok)

endmodule
